// ===== rtl/axis_angle_point_rotator_defines.svh =====
// Assertion macros shared by the point rotator RTL.
`ifndef AXIS_ANGLE_POINT_ROTATOR_DEFINES_SVH
`define AXIS_ANGLE_POINT_ROTATOR_DEFINES_SVH

// Checked only outside reset.
`define AAPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define AAPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/aapr_pkg.sv =====
// Shared widths, constants, payload types and the arctangent table of the point rotator.
`timescale 1ns / 1ps
package aapr_pkg;

  localparam int TRIG_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int ATAN_IDX_W      = $clog2(ATAN_ENTRIES);

  localparam int ANG_W = 35;
  localparam int Z_W   = 33;
  localparam int XY_W  = 34;
  localparam int OMC_W = 35;
  localparam int AA_W  = 32;
  localparam int AS_W  = 50;
  localparam int ACC_W = 67;
  localparam int M_W   = 30;
  localparam int PR_W  = 63;
  localparam int SUM_W = 65;
  localparam int RS_W  = 41;
  localparam int V_W   = 42;

  localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [Z_W-1:0]   Z_HALF_PI   = 33'sd1686629713;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [OMC_W-1:0] Q30_ONE     = 35'sd1073741824;

  typedef logic signed [31:0]     coord_t;
  typedef logic signed [32:0]     delta_t;
  typedef logic signed [15:0]     axis_t;
  typedef logic signed [M_W-1:0]  ment_t;

  typedef struct packed {
    coord_t [2:0] pivot;
    delta_t [2:0] delta;
    axis_t  [2:0] axis;
  } geo_t;

  typedef struct packed {
    coord_t [2:0] pivot;
    delta_t [2:0] delta;
    ment_t  [8:0] m;
  } rot_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:  r = 33'sd843314856;
      5'd1:  r = 33'sd497837829;
      5'd2:  r = 33'sd263043836;
      5'd3:  r = 33'sd133525158;
      5'd4:  r = 33'sd67021686;
      5'd5:  r = 33'sd33543515;
      5'd6:  r = 33'sd16775850;
      5'd7:  r = 33'sd8388437;
      5'd8:  r = 33'sd4194282;
      5'd9:  r = 33'sd2097149;
      5'd10: r = 33'sd1048575;
      5'd11: r = 33'sd524287;
      5'd12: r = 33'sd262143;
      5'd13: r = 33'sd131071;
      5'd14: r = 33'sd65535;
      5'd15: r = 33'sd32767;
      5'd16: r = 33'sd16383;
      5'd17: r = 33'sd8191;
      5'd18: r = 33'sd4095;
      5'd19: r = 33'sd2047;
      5'd20: r = 33'sd1023;
      5'd21: r = 33'sd511;
      5'd22: r = 33'sd255;
      5'd23: r = 33'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/axis_angle_point_rotator.sv =====
// Top level: rotates a point about a pivot by an axis-angle rotation, fully pipelined.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   request | req_valid/req_ready  | pivot_x..z, point_x..z, axis_x..z, angle
//   result  | res_valid/res_ready  | out_x, out_y, out_z
//
// The pipeline has one reduction stage, one CORDIC stage per micro-rotation, three matrix
// stages and three apply stages.
// A request enters every cycle unless stalled; a stage holds its item if the next is full.
// Synchronous reset clears every stage valid bit; payload registers are not reset.
`timescale 1ns / 1ps
`include "axis_angle_point_rotator_defines.svh"
module axis_angle_point_rotator #(
  parameter int TRIG_STAGES = aapr_pkg::TRIG_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic signed [31:0] pivot_x,
  input  logic signed [31:0] pivot_y,
  input  logic signed [31:0] pivot_z,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [16:0] angle,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  import aapr_pkg::*;

  logic                   rg_valid, rg_ready, cd_valid, cd_ready, mx_valid, mx_ready;
  logic signed [Z_W-1:0]  rg_z;
  logic                   rg_flip, cd_flip;
  geo_t                   rg_geo, cd_geo;
  logic signed [XY_W-1:0] cd_x, cd_y;
  rot_t                   mx_rot;
  coord_t [2:0]           result;

  aapr_range u_range (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .pivot    ({pivot_z, pivot_y, pivot_x}),
    .point    ({point_z, point_y, point_x}),
    .axis     ({axis_z, axis_y, axis_x}),
    .angle    (angle),
    .dn_valid (rg_valid),
    .dn_ready (rg_ready),
    .z        (rg_z),
    .flip     (rg_flip),
    .geo      (rg_geo)
  );

  aapr_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rg_valid),
    .up_ready (rg_ready),
    .z_in     (rg_z),
    .flip_in  (rg_flip),
    .geo_in   (rg_geo),
    .dn_valid (cd_valid),
    .dn_ready (cd_ready),
    .x_out    (cd_x),
    .y_out    (cd_y),
    .flip_out (cd_flip),
    .geo_out  (cd_geo)
  );

  aapr_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cd_valid),
    .up_ready (cd_ready),
    .x_in     (cd_x),
    .y_in     (cd_y),
    .flip_in  (cd_flip),
    .geo_in   (cd_geo),
    .dn_valid (mx_valid),
    .dn_ready (mx_ready),
    .rot      (mx_rot)
  );

  aapr_apply u_apply (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mx_valid),
    .up_ready (mx_ready),
    .rot      (mx_rot),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .result   (result)
  );

  assign out_x = result[0];
  assign out_y = result[1];
  assign out_z = result[2];

  `AAPR_ASSERT(a_full_stall, !req_ready |-> (res_valid && !res_ready), "request blocked with output free")
  `AAPR_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !res_valid, "result valid right after reset")

endmodule

// ===== rtl/aapr_range.sv =====
// Entry stage: angle reduction into the CORDIC range and point offset from the pivot.
`timescale 1ns / 1ps
`include "axis_angle_point_rotator_defines.svh"
module aapr_range (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  aapr_pkg::coord_t [2:0] pivot,
  input  aapr_pkg::coord_t [2:0] point,
  input  aapr_pkg::axis_t  [2:0] axis,
  input  logic signed [16:0]    angle,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic signed [aapr_pkg::Z_W-1:0] z,
  output logic                  flip,
  output aapr_pkg::geo_t        geo
);
  import aapr_pkg::*;

  logic signed [ANG_W-1:0] t0, t1, t2, t3, t4, tf;
  logic                    flip_next;
  geo_t                    geo_next;

  always_comb begin
    t0 = {angle[16], angle, 17'b0};
    t1 = (t0 > Q30_PI) ? t0 - Q30_TWO_PI : t0;
    t2 = (t1 > Q30_PI) ? t1 - Q30_TWO_PI : t1;
    t3 = (t2 < -Q30_PI) ? t2 + Q30_TWO_PI : t2;
    t4 = (t3 < -Q30_PI) ? t3 + Q30_TWO_PI : t3;
    priority if (t4 > Q30_HALF_PI) begin
      tf = t4 - Q30_PI;
      flip_next = 1'b1;
    end else if (t4 < -Q30_HALF_PI) begin
      tf = t4 + Q30_PI;
      flip_next = 1'b1;
    end else begin
      tf = t4;
      flip_next = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo_next.pivot[i] = pivot[i];
      geo_next.delta[i] = 33'($signed(point[i])) - 33'($signed(pivot[i]));
      geo_next.axis[i]  = axis[i];
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      z    <= tf[Z_W-1:0];
      flip <= flip_next;
      geo  <= geo_next;
    end
  end

  `AAPR_ASSERT(a_fold_range, dn_valid |-> (z <= Z_HALF_PI && z >= -Z_HALF_PI), "reduced angle outside half pi")

endmodule

// ===== rtl/aapr_cordic.sv =====
// Rotation-mode CORDIC pipeline, one micro-rotation per register stage.
`timescale 1ns / 1ps
module aapr_cordic #(
  parameter int TRIG_STAGES = aapr_pkg::TRIG_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [aapr_pkg::Z_W-1:0] z_in,
  input  logic                  flip_in,
  input  aapr_pkg::geo_t        geo_in,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic signed [aapr_pkg::XY_W-1:0] x_out,
  output logic signed [aapr_pkg::XY_W-1:0] y_out,
  output logic                  flip_out,
  output aapr_pkg::geo_t        geo_out
);
  import aapr_pkg::*;

  logic [TRIG_STAGES-1:0]   v;
  logic [TRIG_STAGES:0]     rdy;
  logic signed [XY_W-1:0]   x_q [TRIG_STAGES];
  logic signed [XY_W-1:0]   y_q [TRIG_STAGES];
  logic signed [Z_W-1:0]    z_q [TRIG_STAGES];
  logic                     f_q [TRIG_STAGES];
  geo_t                     g_q [TRIG_STAGES];

  assign rdy[TRIG_STAGES] = dn_ready;
  assign up_ready = rdy[0];

  for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_stage
    logic signed [XY_W-1:0] xi, yi, xs, ys;
    logic signed [Z_W-1:0]  zi, at;
    logic                   fi, vi;
    geo_t                   gi;

    if (k == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_in;
      assign fi = flip_in;
      assign gi = geo_in;
      assign vi = up_valid;
    end else begin : g_rest
      assign xi = x_q[k-1];
      assign yi = y_q[k-1];
      assign zi = z_q[k-1];
      assign fi = f_q[k-1];
      assign gi = g_q[k-1];
      assign vi = v[k-1];
    end

    assign xs = xi >>> k;
    assign ys = yi >>> k;
    assign at = atan_q30(ATAN_IDX_W'(k));
    assign rdy[k] = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (vi && rdy[k]) begin
        if (!zi[Z_W-1]) begin
          x_q[k] <= xi - ys;
          y_q[k] <= yi + xs;
          z_q[k] <= zi - at;
        end else begin
          x_q[k] <= xi + ys;
          y_q[k] <= yi - xs;
          z_q[k] <= zi + at;
        end
        f_q[k] <= fi;
        g_q[k] <= gi;
      end
    end
  end

  assign dn_valid = v[TRIG_STAGES-1];
  assign x_out    = x_q[TRIG_STAGES-1];
  assign y_out    = y_q[TRIG_STAGES-1];
  assign flip_out = f_q[TRIG_STAGES-1];
  assign geo_out  = g_q[TRIG_STAGES-1];

endmodule

// ===== rtl/aapr_matrix.sv =====
// Rotation matrix build: sign fix of cos and sin, axis products, Q24 matrix entries.
`timescale 1ns / 1ps
module aapr_matrix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic signed [aapr_pkg::XY_W-1:0] x_in,
  input  logic signed [aapr_pkg::XY_W-1:0] y_in,
  input  logic                  flip_in,
  input  aapr_pkg::geo_t        geo_in,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output aapr_pkg::rot_t        rot
);
  import aapr_pkg::*;

  logic                   vf, v1;
  logic                   rdy_f, rdy_1, rdy_2;
  logic signed [XY_W-1:0] cf, sf, c1;
  logic signed [OMC_W-1:0] omcf, omc1;
  geo_t                   gf;
  coord_t [2:0]           piv1;
  delta_t [2:0]           del1;
  logic signed [AA_W-1:0] aa_q [9];
  logic signed [AS_W-1:0] as_q [3];
  logic signed [XY_W-1:0] c_next, s_next;
  ment_t  [8:0]           m_next;

  assign rdy_2    = !dn_valid || dn_ready;
  assign rdy_1    = !v1 || rdy_2;
  assign rdy_f    = !vf || rdy_1;
  assign up_ready = rdy_f;

  assign c_next = flip_in ? -x_in : x_in;
  assign s_next = flip_in ? -y_in : y_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf       <= 1'b0;
      v1       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy_f) vf <= up_valid;
      if (rdy_1) v1 <= vf;
      if (rdy_2) dn_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_f) begin
      cf   <= c_next;
      sf   <= s_next;
      omcf <= Q30_ONE - OMC_W'(c_next);
      gf   <= geo_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vf && rdy_1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          aa_q[4'(3*i+j)] <= AA_W'($signed(gf.axis[i]) * $signed(gf.axis[j]));
        end
        as_q[2'(i)] <= AS_W'($signed(gf.axis[i])) * AS_W'(sf);
      end
      c1   <= cf;
      omc1 <= omcf;
      piv1 <= gf.pivot;
      del1 <= gf.delta;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sterm;
    logic                    plus;
    int                      k;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k     = 3 - i - j;
        plus  = (i == 0 && j == 2) || (i == 1 && j == 0) || (i == 2 && j == 1);
        acc   = ACC_W'(aa_q[4'(3*i+j)]) * ACC_W'(omc1);
        sterm = '0;
        if (i == j) begin
          acc = acc + (ACC_W'(c1) <<< 28);
        end else begin
          sterm = ACC_W'(as_q[2'(k)]) <<< 14;
          if (plus) begin
            acc = acc + sterm;
          end else begin
            acc = acc - sterm;
          end
        end
        acc = acc + (ACC_W'(1) <<< 33);
        m_next[3*i+j] = acc[M_W+33:34];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy_2) begin
      rot.pivot <= piv1;
      rot.delta <= del1;
      rot.m     <= m_next;
    end
  end

endmodule

// ===== rtl/aapr_apply.sv =====
// Matrix times offset, Q24 rounding, pivot add and output saturation.
`timescale 1ns / 1ps
module aapr_apply (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  aapr_pkg::rot_t rot,
  output logic           dn_valid,
  input  logic           dn_ready,
  output aapr_pkg::coord_t [2:0] result
);
  import aapr_pkg::*;

  logic                   v3, v4;
  logic                   rdy_3, rdy_4, rdy_5;
  logic signed [PR_W-1:0] pr_q [9];
  coord_t [2:0]           piv3, piv4;
  logic signed [RS_W-1:0] rs_q [3];
  logic signed [RS_W-1:0] rs_next [3];
  coord_t [2:0]           res_next;

  assign rdy_5    = !dn_valid || dn_ready;
  assign rdy_4    = !v4 || rdy_5;
  assign rdy_3    = !v3 || rdy_4;
  assign up_ready = rdy_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3       <= 1'b0;
      v4       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy_3) v3 <= up_valid;
      if (rdy_4) v4 <= v3;
      if (rdy_5) dn_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[4'(3*i+j)] <= PR_W'($signed(rot.m[3*i+j])) * PR_W'($signed(rot.delta[j]));
        end
      end
      piv3 <= rot.pivot;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = SUM_W'(pr_q[4'(3*i)]) + SUM_W'(pr_q[4'(3*i+1)]) + SUM_W'(pr_q[4'(3*i+2)])
          + (SUM_W'(1) <<< 23);
      rs_next[2'(i)] = sum[SUM_W-1:24];
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy_4) begin
      for (int i = 0; i < 3; i++) rs_q[2'(i)] <= rs_next[2'(i)];
      piv4 <= piv3;
    end
  end

  always_comb begin
    logic signed [V_W-1:0] v;
    for (int i = 0; i < 3; i++) begin
      v = V_W'($signed(piv4[i])) + V_W'(rs_q[2'(i)]);
      priority if (v > V_W'(32'sh7fffffff)) begin
        res_next[i] = 32'sh7fffffff;
      end else if (v < V_W'(-33'sh80000000)) begin
        res_next[i] = 32'sh80000000;
      end else begin
        res_next[i] = v[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && rdy_5) begin
      result <= res_next;
    end
  end

endmodule
